[rtl/sidechain_noise_gate_assert.svh]
// Assertion macros for the side-chain noise gate
`ifndef SIDECHAIN_NOISE_GATE_ASSERT_SVH
`define SIDECHAIN_NOISE_GATE_ASSERT_SVH

`ifndef ASSERT_OFF

`define SNG_ASSERT_IMP(name, ck, rs, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
        else $error("sng: implication check failed");

`define SNG_ASSERT_NXT(name, ck, rs, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
        else $error("sng: next-cycle check failed");

`else

`define SNG_ASSERT_IMP(name, ck, rs, ante, cons)

`define SNG_ASSERT_NXT(name, ck, rs, ante, cons)

`endif

`endif

[rtl/sng_pkg.sv]
// Shared constants, types and helpers for the side-chain noise gate
package sng_pkg;

    localparam int MAIN_CHANNELS = 2;
    localparam int AUX_CHANNELS  = 2;
    localparam int SMP_W         = 24;
    localparam int CH_W          = (MAIN_CHANNELS > 1) ? $clog2(MAIN_CHANNELS) : 1;

    localparam int THR_W   = 24;
    localparam int RATIO_W = 20;
    localparam int COEF_W  = 25;
    localparam int CNT_W   = 2;
    localparam int GAIN_W  = 25;
    localparam int ENV_W   = 24;
    localparam int PROD_W  = 49;

    localparam int CFG_W  = 25;
    localparam int CFG_AW = 3;

    localparam int DIV_STEPS = 24;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1) << (GAIN_W - 1);

    localparam logic [CFG_AW-1:0] REG_THRESHOLD  = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_RATIO      = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] REG_ATTACK     = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] REG_RELEASE    = CFG_AW'(3);
    localparam logic [CFG_AW-1:0] REG_MAIN_COUNT = CFG_AW'(4);
    localparam logic [CFG_AW-1:0] REG_AUX_COUNT  = CFG_AW'(5);

    typedef logic signed [SMP_W-1:0] smp_t;

    typedef struct packed {
        logic            capture;
        logic            env_mul;
        logic            env_upd;
        logic            gain_mul;
        logic            gain_chk;
        logic            div_step;
        logic            div_last;
        logic            scl_mul;
        logic            scl_rnd;
        logic            load_out;
        logic [CH_W-1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic need_div;
    } sts_t;

    function automatic logic [SMP_W-1:0] mag(input smp_t x);
        logic [SMP_W-1:0] u;
        u = x;
        return x[SMP_W-1] ? (~u + SMP_W'(1)) : u;
    endfunction

endpackage

[rtl/sng_in_if.sv]
// Input item channel: one frame of main and side-chain samples
interface sng_in_if;
    logic                 valid;
    logic                 ready;
    sng_pkg::smp_t        main_0;
    sng_pkg::smp_t        main_1;
    sng_pkg::smp_t        aux_0;
    sng_pkg::smp_t        aux_1;

    modport source (output valid, output main_0, output main_1, output aux_0,
                    output aux_1, input ready);
    modport sink   (input valid, input main_0, input main_1, input aux_0,
                    input aux_1, output ready);
endinterface

[rtl/sng_out_if.sv]
// Result item channel: gated main samples and the applied gain
interface sng_out_if;
    logic                          valid;
    logic                          ready;
    sng_pkg::smp_t                 out_0;
    sng_pkg::smp_t                 out_1;
    logic [sng_pkg::GAIN_W-1:0]    applied_gain;

    modport source (output valid, output out_0, output out_1, output applied_gain,
                    input ready);
    modport sink   (input valid, input out_0, input out_1, input applied_gain,
                    output ready);
endinterface

[rtl/sng_ctrl.sv]
// Sequencer for the noise gate: steps the datapath through one item
module sng_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output sng_pkg::cmd_t cmd,
    input  sng_pkg::sts_t sts
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ENV_MUL  = 4'd1;
    localparam logic [3:0] S_ENV_UPD  = 4'd2;
    localparam logic [3:0] S_GAIN_MUL = 4'd3;
    localparam logic [3:0] S_GAIN_CHK = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_SCL_MUL  = 4'd6;
    localparam logic [3:0] S_SCL_RND  = 4'd7;
    localparam logic [3:0] S_WRITE    = 4'd8;

    logic [3:0]                  state_reg, state_next;
    logic [sng_pkg::DIV_CW-1:0]  cnt_reg, cnt_next;
    logic [sng_pkg::CH_W-1:0]    ch_reg, ch_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;
    logic                        div_last;
    logic                        ch_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign div_last  = (cnt_reg == sng_pkg::DIV_CW'(sng_pkg::DIV_STEPS - 1));
    assign ch_last   = (ch_reg == sng_pkg::CH_W'(sng_pkg::MAIN_CHANNELS - 1));
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_ENV_MUL;
                end
            end
            S_ENV_MUL:
            begin
                cmd.env_mul = 1'b1;
                state_next  = S_ENV_UPD;
            end
            S_ENV_UPD:
            begin
                cmd.env_upd = 1'b1;
                state_next  = S_GAIN_MUL;
            end
            S_GAIN_MUL:
            begin
                cmd.gain_mul = 1'b1;
                state_next   = S_GAIN_CHK;
            end
            S_GAIN_CHK:
            begin
                cmd.gain_chk = 1'b1;
                cnt_next     = '0;
                ch_next      = '0;
                state_next   = sts.need_div ? S_DIV : S_SCL_MUL;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = div_last;
                cnt_next     = cnt_reg + sng_pkg::DIV_CW'(1);
                if (div_last)
                begin
                    state_next = S_SCL_MUL;
                end
            end
            S_SCL_MUL:
            begin
                cmd.scl_mul = 1'b1;
                state_next  = S_SCL_RND;
            end
            S_SCL_RND:
            begin
                cmd.scl_rnd = 1'b1;
                ch_next     = ch_reg + sng_pkg::CH_W'(1);
                state_next  = ch_last ? S_WRITE : S_SCL_MUL;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/sng_dp.sv]
// Datapath for the noise gate: registers, detector, envelope, divider, scaler
module sng_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sng_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [sng_pkg::CFG_W-1:0]   cfg_data,
    input  sng_pkg::smp_t               main_in [sng_pkg::MAIN_CHANNELS],
    input  sng_pkg::smp_t               aux_in  [sng_pkg::AUX_CHANNELS],
    input  sng_pkg::cmd_t               cmd,
    output sng_pkg::sts_t               sts,
    output sng_pkg::smp_t               res_out [sng_pkg::MAIN_CHANNELS],
    output logic [sng_pkg::GAIN_W-1:0]  gain_out
);

    localparam int SW = sng_pkg::SMP_W;
    localparam int EW = sng_pkg::ENV_W;
    localparam int GW = sng_pkg::GAIN_W;
    localparam int PW = sng_pkg::PROD_W;
    localparam int NW = sng_pkg::THR_W + 16;

    // configuration
    logic [sng_pkg::THR_W-1:0]   thr_reg;
    logic [sng_pkg::RATIO_W-1:0] ratio_reg;
    logic [sng_pkg::COEF_W-1:0]  atk_reg;
    logic [sng_pkg::COEF_W-1:0]  rel_reg;
    logic [sng_pkg::CNT_W-1:0]   mcnt_reg;
    logic [sng_pkg::CNT_W-1:0]   acnt_reg;

    // per-item state
    sng_pkg::smp_t          main_reg [sng_pkg::MAIN_CHANNELS];
    sng_pkg::smp_t          res_reg  [sng_pkg::MAIN_CHANNELS];
    sng_pkg::smp_t          out_reg  [sng_pkg::MAIN_CHANNELS];
    logic [EW-1:0]          det_reg, det_next;
    logic [EW-1:0]          env_reg, env_next;
    logic                   up_reg;
    logic [PW-1:0]          prod_reg;
    logic [GW-1:0]          gain_reg, gain_next;
    logic [GW-1:0]          out_gain_reg;
    logic [EW-1:0]          rem_reg, rem_next;
    logic [EW-1:0]          quo_reg, quo_next;

    logic [sng_pkg::CNT_W-1:0] nm, na;
    logic [SW-1:0]          mag0, mag1;
    logic [SW:0]            mag_sum;
    logic                   up;
    logic [EW-1:0]          env_diff;
    logic [sng_pkg::COEF_W-1:0] coef_raw, coef_sat;
    logic [GW-1:0]          mul_a;
    logic [EW-1:0]          mul_b;
    logic [PW-1:0]          mul_p;
    logic [EW-1:0]          step;
    logic [EW-1:0]          env_moved;
    logic                   open;
    logic signed [NW+4:0]   num_s;
    logic [NW-1:0]          num_u;
    logic                   num_pos;
    logic                   sat;
    logic [EW:0]            div_r2;
    logic                   div_ge;
    logic [EW:0]            div_sub;
    logic [PW-2:0]          rnd_sum;
    logic [SW-1:0]          rnd_mag;
    sng_pkg::smp_t          cur_x;
    sng_pkg::smp_t          scaled;
    logic                   ch_active;

    assign nm = (mcnt_reg > sng_pkg::CNT_W'(sng_pkg::MAIN_CHANNELS))
              ? sng_pkg::CNT_W'(sng_pkg::MAIN_CHANNELS) : mcnt_reg;
    assign na = (acnt_reg > sng_pkg::CNT_W'(sng_pkg::AUX_CHANNELS))
              ? sng_pkg::CNT_W'(sng_pkg::AUX_CHANNELS) : acnt_reg;

    // detector: mean magnitude of the active side-chain samples
    assign mag0    = sng_pkg::mag(aux_in[0]);
    assign mag1    = sng_pkg::mag(aux_in[1]);
    assign mag_sum = {1'b0, mag0} + {1'b0, mag1};

    always_comb
    begin
        case (na)
            sng_pkg::CNT_W'(0): det_next = '0;
            sng_pkg::CNT_W'(1): det_next = mag0;
            default:            det_next = mag_sum[SW:1];
        endcase
    end

    // envelope follower
    assign up       = det_reg > env_reg;
    assign env_diff = up ? (det_reg - env_reg) : (env_reg - det_reg);
    assign coef_raw = up ? atk_reg : rel_reg;
    assign coef_sat = (coef_raw > sng_pkg::UNITY) ? sng_pkg::UNITY : coef_raw;
    assign step     = prod_reg[2*EW-1:EW];
    assign env_moved = up_reg ? (env_reg + step) : (env_reg - step);
    assign env_next  = (env_moved == '0) ? EW'(1) : env_moved;

    // gain check
    assign open    = env_reg >= thr_reg;
    assign num_s   = $signed({5'd0, thr_reg, 16'd0}) - $signed({1'b0, prod_reg[NW+3:0]});
    assign num_pos = !num_s[NW+4] && (num_s != '0);
    assign num_u   = num_s[NW-1:0];
    assign sat     = num_u >= {env_reg, 16'd0};
    assign sts.need_div = !open && num_pos && !sat;

    // restoring divider, one quotient bit per step
    assign div_r2   = {rem_reg, quo_reg[EW-1]};
    assign div_ge   = div_r2 >= {1'b0, env_reg};
    assign div_sub  = div_r2 - {1'b0, env_reg};
    assign rem_next = div_ge ? div_sub[EW-1:0] : div_r2[EW-1:0];
    assign quo_next = {quo_reg[EW-2:0], div_ge};

    always_comb
    begin
        gain_next = gain_reg;
        if (cmd.gain_chk)
        begin
            if (open)
            begin
                gain_next = sng_pkg::UNITY;
            end
            else if (!num_pos)
            begin
                gain_next = '0;
            end
            else if (sat)
            begin
                gain_next = sng_pkg::UNITY;
            end
        end
        else if (cmd.div_last)
        begin
            gain_next = {1'b0, quo_next};
        end
    end

    // shared multiplier operands
    assign cur_x = main_reg[cmd.ch];

    always_comb
    begin
        if (cmd.env_mul)
        begin
            mul_a = coef_sat;
            mul_b = env_diff;
        end
        else if (cmd.gain_mul)
        begin
            mul_a = GW'(ratio_reg);
            mul_b = thr_reg - env_reg;
        end
        else
        begin
            mul_a = gain_reg;
            mul_b = sng_pkg::mag(cur_x);
        end
    end

    assign mul_p = mul_a * mul_b;

    // sample scaling with rounding to nearest, ties away from zero
    assign rnd_sum   = prod_reg[PW-2:0] + (PW-1)'(1 << (SW - 1));
    assign rnd_mag   = rnd_sum[PW-2:SW];
    assign scaled    = cur_x[SW-1] ? (~rnd_mag + SW'(1)) : rnd_mag;
    assign ch_active = sng_pkg::CNT_W'(cmd.ch) < nm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= sng_pkg::THR_W'(8388608);
            ratio_reg <= sng_pkg::RATIO_W'(65536);
            atk_reg   <= '0;
            rel_reg   <= '0;
            mcnt_reg  <= sng_pkg::CNT_W'(2);
            acnt_reg  <= '0;
            env_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    sng_pkg::REG_THRESHOLD:  thr_reg   <= cfg_data[sng_pkg::THR_W-1:0];
                    sng_pkg::REG_RATIO:      ratio_reg <= cfg_data[sng_pkg::RATIO_W-1:0];
                    sng_pkg::REG_ATTACK:     atk_reg   <= cfg_data[sng_pkg::COEF_W-1:0];
                    sng_pkg::REG_RELEASE:    rel_reg   <= cfg_data[sng_pkg::COEF_W-1:0];
                    sng_pkg::REG_MAIN_COUNT: mcnt_reg  <= cfg_data[sng_pkg::CNT_W-1:0];
                    sng_pkg::REG_AUX_COUNT:  acnt_reg  <= cfg_data[sng_pkg::CNT_W-1:0];
                    default:                 ;
                endcase
            end
            if (cmd.env_upd)
            begin
                env_reg <= env_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            main_reg <= main_in;
            det_reg  <= det_next;
        end
        if (cmd.env_mul)
        begin
            up_reg <= up;
        end
        if (cmd.env_mul || cmd.gain_mul || cmd.scl_mul)
        begin
            prod_reg <= mul_p;
        end
        gain_reg <= gain_next;
        if (cmd.gain_chk)
        begin
            rem_reg <= num_u[NW-1:16];
            quo_reg <= {num_u[15:0], 8'd0};
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.scl_rnd)
        begin
            res_reg[cmd.ch] <= ch_active ? scaled : cur_x;
        end
        if (cmd.load_out)
        begin
            out_reg      <= res_reg;
            out_gain_reg <= gain_reg;
        end
    end

    assign res_out  = out_reg;
    assign gain_out = out_gain_reg;

endmodule

[rtl/sidechain_noise_gate.sv]
// Side-chain keyed noise gate (downward expander), top level
//
// Items enter on din (two main samples, two side-chain samples, signed
// Q1.23) and leave on dout (two gated samples and the Q1.24 gain used).
// Registers are written through cfg_we / cfg_addr / cfg_data; the user
// must do so only while idle, as the block itself does not enforce it.
// One item is processed at a time: capture, envelope update, gain,
// the 24-step restoring divider (skipped when the envelope is at or
// above threshold or the gain clamps), scaling of each main channel
// and output load. The single shared 25x24 multiplier serves the steps.
// din.ready is high only while the sequencer is idle; a finished item
// waits in the output register, so the next item may be accepted while
// dout is stalled. A second finished item waits in the datapath until the
// output register is taken.
// Reset clears the envelope, loads the register defaults and empties
// the output register.
`include "sidechain_noise_gate_assert.svh"
module sidechain_noise_gate
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sng_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [sng_pkg::CFG_W-1:0]   cfg_data,
    sng_in_if.sink                      din,
    sng_out_if.source                   dout
);

    sng_pkg::cmd_t  cmd;
    sng_pkg::sts_t  sts;
    sng_pkg::smp_t  main_arr [sng_pkg::MAIN_CHANNELS];
    sng_pkg::smp_t  aux_arr  [sng_pkg::AUX_CHANNELS];
    sng_pkg::smp_t  res_arr  [sng_pkg::MAIN_CHANNELS];
    logic [sng_pkg::GAIN_W-1:0] gain;

    assign main_arr[0] = din.main_0;
    assign main_arr[1] = din.main_1;
    assign aux_arr[0]  = din.aux_0;
    assign aux_arr[1]  = din.aux_1;

    sng_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sng_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .main_in  (main_arr),
        .aux_in   (aux_arr),
        .cmd      (cmd),
        .sts      (sts),
        .res_out  (res_arr),
        .gain_out (gain)
    );

    assign dout.out_0        = res_arr[0];
    assign dout.out_1        = res_arr[1];
    assign dout.applied_gain = gain;

    `SNG_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load_out, !dout.valid || dout.ready)
    `SNG_ASSERT_NXT(a_one_item, clk, rst_n, din.valid && din.ready, !din.ready)
    `SNG_ASSERT_IMP(a_gain_range, clk, rst_n, dout.valid, dout.applied_gain <= sng_pkg::UNITY)

endmodule
